[rtl/pgw_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the page table walker.
// No dependencies; used by pgw_step and page_table_walker_unit.
package pgw_pkg;

    localparam int LINEAR_ADDR_BITS = 48;
    localparam int PHYS_ADDR_BITS   = 32;

    // Field widths of the stream items
    localparam int LA_FIELD_W    = 48;
    localparam int ROOT_FIELD_W  = 32;
    localparam int ENTRY_FIELD_W = 64;
    localparam int ADDR_FIELD_W  = 32;
    localparam int IN_TDATA_W    = LA_FIELD_W + ROOT_FIELD_W + ENTRY_FIELD_W;
    localparam int OUT_TDATA_W   = ((ADDR_FIELD_W + 2 + 7) / 8) * 8;

    localparam logic [63:0] PHYS_MASK64 = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [31:0] PHYS_MASK32 = PHYS_MASK64[31:0];

    localparam logic [31:0] MASK_4K_BASE = 32'hFFFF_F000;
    localparam logic [31:0] MASK_1G_BASE = 32'hC000_0000;
    localparam logic [31:0] MASK_2M_BASE = 32'hFFE0_0000;
    localparam logic [31:0] MASK_4M_BASE = 32'hFFC0_0000;
    localparam logic [31:0] MASK_1G_OFS  = 32'h3FFF_FFFF;
    localparam logic [31:0] MASK_2M_OFS  = 32'h001F_FFFF;
    localparam logic [31:0] MASK_4M_OFS  = 32'h003F_FFFF;
    localparam logic [31:0] MASK_4K_OFS  = 32'h0000_0FFF;

    localparam int PRESENT_BIT   = 0;
    localparam int PAGE_SIZE_BIT = 7;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_FAULT   = 2'd2,
        KIND_IGNORED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PSIZE_4K = 2'd0,
        PSIZE_2M = 2'd1,
        PSIZE_4M = 2'd2,
        PSIZE_1G = 2'd3
    } t_psize;

    // Table levels already asked for, top first
    typedef enum logic [1:0] {
        LVL_TOP    = 2'd0,
        LVL_SECOND = 2'd1,
        LVL_THIRD  = 2'd2,
        LVL_LEAF   = 2'd3
    } t_level;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        address;
        t_psize             psize;
    } t_step_out;

    typedef struct packed {
        logic   busy;
        t_level level;
    } t_walk_state;

endpackage

[rtl/pgw_step.sv]
`timescale 1ns / 1ps
// One walk step: decodes an item against the walk state and builds the result.
// Depends on pgw_pkg.
module pgw_step (
    input  logic                                  i_mode_four,
    input  logic                                  i_cmd,
    input  logic [pgw_pkg::LA_FIELD_W-1:0]        i_linear_addr,
    input  logic [pgw_pkg::ROOT_FIELD_W-1:0]      i_table_root,
    input  logic [pgw_pkg::ENTRY_FIELD_W-1:0]     i_entry_data,
    input  pgw_pkg::t_walk_state                  i_state,
    input  logic [pgw_pkg::LINEAR_ADDR_BITS-1:0]  i_held_addr,
    output pgw_pkg::t_walk_state                  o_state,
    output logic                                  o_load_held,
    output pgw_pkg::t_step_out                    o_result
);
    import pgw_pkg::*;

    logic [63:0] held64;
    logic [63:0] start64;
    logic [31:0] root32;
    logic [31:0] e32;
    logic [31:0] la32;
    logic [31:0] base4k;

    always_comb begin
        held64  = {{(64-LINEAR_ADDR_BITS){1'b0}}, i_held_addr};
        start64 = {{(64-LINEAR_ADDR_BITS){1'b0}}, i_linear_addr[LINEAR_ADDR_BITS-1:0]};
        root32  = i_table_root & MASK_4K_BASE;
        e32     = i_entry_data[31:0];
        la32    = held64[31:0];
        base4k  = e32 & MASK_4K_BASE & PHYS_MASK32;

        o_state          = i_state;
        o_load_held      = 1'b0;
        o_result.kind    = KIND_IGNORED;
        o_result.address = '0;
        o_result.psize   = PSIZE_4K;

        if (i_cmd == CMD_START) begin
            if (!i_state.busy) begin
                o_load_held    = 1'b1;
                o_state.busy   = 1'b1;
                o_state.level  = LVL_TOP;
                o_result.kind  = KIND_READ;
                if (i_mode_four) begin
                    o_result.address = (root32 & PHYS_MASK32)
                                     | {20'd0, start64[47:39], 3'd0};
                end else begin
                    o_result.address = root32 + {20'd0, start64[31:22], 2'd0};
                end
            end
        end else if (i_state.busy) begin
            if (!i_entry_data[PRESENT_BIT]) begin
                // not present: end the walk with a fault
                o_state.busy  = 1'b0;
                o_state.level = LVL_TOP;
                o_result.kind = KIND_FAULT;
            end else if (i_mode_four) begin
                unique case (i_state.level)
                    LVL_TOP: begin
                        o_state.level    = LVL_SECOND;
                        o_result.kind    = KIND_READ;
                        o_result.address = base4k | {20'd0, held64[38:30], 3'd0};
                    end
                    LVL_SECOND: begin
                        if (i_entry_data[PAGE_SIZE_BIT]) begin
                            o_state.busy     = 1'b0;
                            o_state.level    = LVL_TOP;
                            o_result.kind    = KIND_DONE;
                            o_result.psize   = PSIZE_1G;
                            o_result.address = (e32 & MASK_1G_BASE & PHYS_MASK32)
                                             + (la32 & MASK_1G_OFS);
                        end else begin
                            o_state.level    = LVL_THIRD;
                            o_result.kind    = KIND_READ;
                            o_result.address = base4k | {20'd0, held64[29:21], 3'd0};
                        end
                    end
                    LVL_THIRD: begin
                        if (i_entry_data[PAGE_SIZE_BIT]) begin
                            o_state.busy     = 1'b0;
                            o_state.level    = LVL_TOP;
                            o_result.kind    = KIND_DONE;
                            o_result.psize   = PSIZE_2M;
                            o_result.address = (e32 & MASK_2M_BASE & PHYS_MASK32)
                                             + (la32 & MASK_2M_OFS);
                        end else begin
                            o_state.level    = LVL_LEAF;
                            o_result.kind    = KIND_READ;
                            o_result.address = base4k | {20'd0, held64[20:12], 3'd0};
                        end
                    end
                    default: begin
                        o_state.busy     = 1'b0;
                        o_state.level    = LVL_TOP;
                        o_result.kind    = KIND_DONE;
                        o_result.address = base4k + (la32 & MASK_4K_OFS);
                    end
                endcase
            end else begin
                if (i_state.level == LVL_TOP) begin
                    if (e32[PAGE_SIZE_BIT]) begin
                        o_state.busy     = 1'b0;
                        o_result.kind    = KIND_DONE;
                        o_result.psize   = PSIZE_4M;
                        o_result.address = (e32 & MASK_4M_BASE) + (la32 & MASK_4M_OFS);
                    end else begin
                        o_state.level    = LVL_SECOND;
                        o_result.kind    = KIND_READ;
                        o_result.address = (e32 & MASK_4K_BASE) + {20'd0, la32[21:12], 2'd0};
                    end
                end else begin
                    // any deeper level counts as the page table here
                    o_state.busy     = 1'b0;
                    o_state.level    = LVL_TOP;
                    o_result.kind    = KIND_DONE;
                    o_result.address = (e32 & MASK_4K_BASE) + (la32 & MASK_4K_OFS);
                end
            end
        end
    end

endmodule

[rtl/page_table_walker_unit.sv]
`timescale 1ns / 1ps
// Page table walker: each item is one table level, result is the next entry
// read, the translation, a fault, or ignored. An accepted item goes from the
// input register through the step logic into the result register; one item
// per cycle is sustained while the output is not stalled, set by the single
// step stage. Synchronous active-low reset idles the walk, clears level, held
// address and mode; no clearing pass. Depends on pgw_pkg and pgw_step.
module page_table_walker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // linear_addr[47:0], table_root[79:48], entry_data[143:80]
    input  logic [pgw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[0]
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // address[31:0], page_size_code[33:32], zero fill above
    output logic [pgw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]                         m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);
    import pgw_pkg::*;

    logic                          r_mode;
    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [LA_FIELD_W-1:0]         r_in_la;
    logic [ROOT_FIELD_W-1:0]       r_in_root;
    logic [ENTRY_FIELD_W-1:0]      r_in_entry;
    t_walk_state                   r_state;
    logic [LINEAR_ADDR_BITS-1:0]   r_held;
    logic                          r_out_valid;
    t_step_out                     r_out;

    t_walk_state                   n_state;
    t_step_out                     n_out;
    logic                          w_load_held;
    logic                          w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    pgw_step u_step (
        .i_mode_four   (r_mode),
        .i_cmd         (r_in_cmd),
        .i_linear_addr (r_in_la),
        .i_table_root  (r_in_root),
        .i_entry_data  (r_in_entry),
        .i_state       (r_state),
        .i_held_addr   (r_held),
        .o_state       (n_state),
        .o_load_held   (w_load_held),
        .o_result      (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser[0];
            r_in_la    <= s_axis_tdata[LA_FIELD_W-1:0];
            r_in_root  <= s_axis_tdata[LA_FIELD_W +: ROOT_FIELD_W];
            r_in_entry <= s_axis_tdata[LA_FIELD_W+ROOT_FIELD_W +: ENTRY_FIELD_W];
        end
    end

    // walk state advances with the item that moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.busy  <= 1'b0;
            r_state.level <= LVL_TOP;
            r_held        <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
            if (w_load_held) begin
                r_held <= r_in_la[LINEAR_ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{(OUT_TDATA_W-ADDR_FIELD_W-2){1'b0}}, r_out.psize, r_out.address};

`ifndef SYNTHESIS
    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.busy |-> r_state.level == LVL_TOP)
        else $error("walker idle with nonzero level");

    a_end_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (n_out.kind == KIND_DONE || n_out.kind == KIND_FAULT)) |=> !r_state.busy)
        else $error("walk still busy after final result");

    a_read_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_out.kind == KIND_READ) |=> r_state.busy)
        else $error("entry read issued without an active walk");

    a_non_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_FAULT || r_out.kind == KIND_IGNORED))
            |-> (r_out.address == '0 && r_out.psize == PSIZE_4K))
        else $error("fault or ignored result carries address or size");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for page_table_walker_unit: drives translate/entry items on the stream
// input, predicts every result from its own walk model and checks the stream output in order.
// Depends on pgw_pkg and the walker RTL only.
module tb_top;
    import pgw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 100;
    localparam int RAND_PHASES = 8;

    typedef struct {
        logic        cmd;
        logic [47:0] la;
        logic [31:0] root;
        logic [63:0] ent;
    } t_walk_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;

    // walk model state
    logic        pw_four = 1'b0;
    logic        pw_busy = 1'b0;
    t_level      pw_level = LVL_TOP;
    logic [47:0] pw_la = '0;

    t_walk_item item_q[$];
    t_step_out  expected_q[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int n_err = 0;
    int n_sent = 0;
    int n_phases = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int cycle_cnt = 0;

    page_table_walker_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // End the walk: idle and back to the top level
    function automatic t_step_out walk_end(t_kind k, logic [31:0] addr, t_psize ps);
        t_step_out r;
        pw_busy  = 1'b0;
        pw_level = LVL_TOP;
        r.kind    = k;
        r.address = addr;
        r.psize   = ps;
        return r;
    endfunction

    // Advance the walk by one accepted item and return the result it causes
    function automatic t_step_out walk_step(logic cmd, logic [47:0] la, logic [31:0] root,
                                            logic [63:0] ent);
        t_step_out   r;
        logic [31:0] base;
        logic [31:0] e32;
        logic [31:0] la32;
        r.kind    = KIND_IGNORED;
        r.address = '0;
        r.psize   = PSIZE_4K;
        base = root & MASK_4K_BASE;
        e32  = ent[31:0];
        la32 = pw_la[31:0];
        if (cmd == CMD_START) begin
            if (!pw_busy) begin
                pw_la    = la;
                pw_busy  = 1'b1;
                pw_level = LVL_TOP;
                r.kind   = KIND_READ;
                if (pw_four)
                    r.address = base | {20'd0, la[47:39], 3'b000};
                else
                    r.address = base + {20'd0, la[31:22], 2'b00};
            end
        end else if (pw_busy) begin
            if (!e32[PRESENT_BIT]) begin
                r = walk_end(KIND_FAULT, '0, PSIZE_4K);
            end else if (pw_four) begin
                case (pw_level)
                    LVL_TOP: begin
                        pw_level  = LVL_SECOND;
                        r.kind    = KIND_READ;
                        r.address = {e32[31:12], pw_la[38:30], 3'b000};
                    end
                    LVL_SECOND: begin
                        if (e32[PAGE_SIZE_BIT]) begin
                            r = walk_end(KIND_DONE, (e32 & MASK_1G_BASE) + (la32 & MASK_1G_OFS),
                                         PSIZE_1G);
                        end else begin
                            pw_level  = LVL_THIRD;
                            r.kind    = KIND_READ;
                            r.address = {e32[31:12], pw_la[29:21], 3'b000};
                        end
                    end
                    LVL_THIRD: begin
                        if (e32[PAGE_SIZE_BIT]) begin
                            r = walk_end(KIND_DONE, (e32 & MASK_2M_BASE) + (la32 & MASK_2M_OFS),
                                         PSIZE_2M);
                        end else begin
                            pw_level  = LVL_LEAF;
                            r.kind    = KIND_READ;
                            r.address = {e32[31:12], pw_la[20:12], 3'b000};
                        end
                    end
                    default: begin
                        r = walk_end(KIND_DONE, (e32 & MASK_4K_BASE) + (la32 & MASK_4K_OFS),
                                     PSIZE_4K);
                    end
                endcase
            end else if (pw_level == LVL_TOP) begin
                if (e32[PAGE_SIZE_BIT]) begin
                    r = walk_end(KIND_DONE, (e32 & MASK_4M_BASE) + (la32 & MASK_4M_OFS),
                                 PSIZE_4M);
                end else begin
                    pw_level  = LVL_SECOND;
                    r.kind    = KIND_READ;
                    r.address = (e32 & MASK_4K_BASE) + {20'd0, la32[21:12], 2'b00};
                end
            end else begin
                // any deeper level is the page table in two-level mode
                r = walk_end(KIND_DONE, (e32 & MASK_4K_BASE) + (la32 & MASK_4K_OFS), PSIZE_4K);
            end
        end
        return r;
    endfunction

    // Driver: offer queued items, predict each one as it is accepted
    always @(posedge i_clk) begin : drv
        t_walk_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(walk_step(s_axis_tuser[0], s_axis_tdata[47:0],
                                               s_axis_tdata[79:48], s_axis_tdata[143:80]));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    it = item_q.pop_front();
                    s_axis_tdata  <= {it.ent, it.root, it.la};
                    s_axis_tuser  <= it.cmd;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, stall at random
    always @(posedge i_clk) begin : mon
        t_step_out want;
        t_kind     got_kind;
        t_psize    got_psize;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_kind  = t_kind'(m_axis_tuser);
                got_psize = t_psize'(m_axis_tdata[33:32]);
                if (expected_q.size() == 0) begin
                    $error("unexpected result: result_kind %0d address %h", got_kind,
                           m_axis_tdata[31:0]);
                    n_err++;
                end else begin
                    want = expected_q.pop_front();
                    kind_seen[want.kind]++;
                    if (got_kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, got_kind);
                        n_err++;
                    end
                    if (m_axis_tdata[31:0] !== want.address) begin
                        $error("address: expected %h, got %h", want.address, m_axis_tdata[31:0]);
                        n_err++;
                    end
                    if (got_psize !== want.psize) begin
                        $error("page_size_code: expected %0d, got %0d", want.psize, got_psize);
                        n_err++;
                    end
                end
            end
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left  <= rx_hold_left - 1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout: %0d results still expected", expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [47:0] rand_la();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [63:0] rand_entry();
        return {32'($urandom), 32'($urandom)};
    endfunction

    task automatic add_item(logic cmd, logic [47:0] la, logic [31:0] root, logic [63:0] ent);
        t_walk_item it;
        it.cmd  = cmd;
        it.la   = la;
        it.root = root;
        it.ent  = ent;
        item_q.push_back(it);
    endtask

    // Queue one walk with random content; now and then break it with stray items
    task automatic add_walk(bit four);
        int          lvl;
        int          last;
        int          r;
        bit          stop;
        logic [63:0] e;
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        last = four ? 3 : 1;
        for (lvl = 0; lvl <= last; lvl++) begin
            if ($urandom_range(99) < 4)
                add_item(CMD_START, rand_la(), $urandom, rand_entry());
            r = $urandom_range(99);
            e = rand_entry();
            stop = (lvl == last);
            if (r < 7) begin
                e[PRESENT_BIT] = 1'b0;
                stop = 1'b1;
            end else begin
                e[PRESENT_BIT] = 1'b1;
                // large page only where the level allows one; top of a long walk ignores it
                if (lvl != last && (!four || lvl != 0)) begin
                    e[PAGE_SIZE_BIT] = (r < 37);
                    stop = (r < 37);
                end
            end
            add_item(CMD_ENTRY, rand_la(), $urandom, e);
            if (stop)
                break;
            if ($urandom_range(99) < 3)
                return;
        end
        if ($urandom_range(99) < 6)
            add_item(CMD_ENTRY, rand_la(), $urandom, rand_entry());
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (item_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    endtask

    task automatic write_mode(logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pw_four = v;
    endtask

    initial begin : stim
        int p;
        int idle_sel;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two-level corners
        write_mode(1'b0);
        add_item(CMD_ENTRY, '1, '1, '1);
        add_item(CMD_START, '0, '0, '0);
        add_item(CMD_ENTRY, '0, '0, '1);
        add_item(CMD_START, '1, '1, '0);
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '1, '1, '1);
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        add_item(CMD_ENTRY, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        add_item(CMD_ENTRY, rand_la(), $urandom, 64'h0000_0000_1234_5001);
        // leave the walk open at the table level across the mode change
        wait_drained();
        n_phases++;

        // four-level corners
        write_mode(1'b1);
        add_item(CMD_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FF7F);
        add_item(CMD_ENTRY, '0, '0, '1);
        add_item(CMD_START, '1, '1, '1);
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '0, '0, '1);
        add_item(CMD_START, '0, '0, '0);
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '0, '0, '1);
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        add_item(CMD_ENTRY, '0, '0, 64'h1);
        add_item(CMD_ENTRY, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        add_item(CMD_START, rand_la(), $urandom, rand_entry());
        add_item(CMD_ENTRY, rand_la(), $urandom, 64'hABCD_0000_8765_4001);
        add_item(CMD_ENTRY, rand_la(), $urandom, 64'h0000_FFFF_0F0F_0001);
        add_item(CMD_ENTRY, rand_la(), $urandom, 64'h5555_5555_5555_5501);
        wait_drained();
        n_phases++;

        // finish a leaf-level walk as a two-level page table entry
        write_mode(1'b0);
        add_item(CMD_ENTRY, rand_la(), $urandom, 64'hFFFF_FFFF_0000_0081);
        wait_drained();
        n_phases++;

        for (p = 0; p < RAND_PHASES; p++) begin
            write_mode(p % 2 == 0);
            idle_sel = p % 4;
            tx_idle_pct  = (idle_sel == 1) ? 72 : (idle_sel == 3) ? 28 : 0;
            rx_stall_pct = (idle_sel == 2) ? 72 : (idle_sel == 3) ? 28 : 0;
            // hold the output off so the block backs up into its input
            if (p == 0)
                rx_hold_left = LONG_HOLD;
            while (item_q.size() < PHASE_ITEMS)
                add_walk(pw_four);
            wait_drained();
            n_phases++;
        end

        repeat (8) @(posedge i_clk);
        $display("covered %0d items over %0d phases in both walk modes", n_sent, n_phases);
        $display("results: %0d reads, %0d translations, %0d faults, %0d ignored",
                 kind_seen[KIND_READ], kind_seen[KIND_DONE], kind_seen[KIND_FAULT],
                 kind_seen[KIND_IGNORED]);
        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pgw_pkg.sv
rtl/pgw_step.sv
rtl/page_table_walker_unit.sv
tb/sv/tb_top.sv
